// ===== rtl/gbte_pkg.sv =====
// ----------------------------------------------------------------------------
// gbte_pkg: shared types and constants for the gap buffer text editor
// Field widths, operation codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package gbte_pkg;

    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 13;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LEFT   = 2'd2,
        OP_RIGHT  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
    } cmd_t;

endpackage

// ===== rtl/gbte_in_if.sv =====
// ----------------------------------------------------------------------------
// gbte_in_if: input item channel
// Valid/ready handshake carrying one editor operation per item.
// ----------------------------------------------------------------------------
interface gbte_in_if
    import gbte_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  text_char;
    logic [COUNT_W-1:0] move_count;

    modport source (output valid, output mode, output text_char, output move_count,
                    input ready);
    modport sink   (input valid, input mode, input text_char, input move_count,
                    output ready);
endinterface

// ===== rtl/gbte_out_if.sv =====
// ----------------------------------------------------------------------------
// gbte_out_if: result item channel
// Valid/ready handshake carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface gbte_out_if
    import gbte_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] deleted_count;
    logic [CHAR_W-1:0]  window_char;
    logic               char_valid;
    logic               last;

    modport source (output valid, output deleted_count, output window_char,
                    output char_valid, output last, input ready);
    modport sink   (input valid, input deleted_count, input window_char,
                    input char_valid, input last, output ready);
endinterface

// ===== rtl/gbte_front.sv =====
// ----------------------------------------------------------------------------
// gbte_front: input acceptance and command queue
// Decode each accepted item into a command and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module gbte_front
    import gbte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gbte_in_if.sink     in_ch,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    cmd_t       dec;

    assign in_ch.ready = (fill_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (fill_reg != 2'd0);
    assign cmd         = q_reg[rd_ptr_reg];

    // Classify the item by mode
    always_comb begin
        dec.ch    = in_ch.text_char;
        dec.count = in_ch.move_count;
        case (in_ch.mode)
            OP_INSERT: dec.op = OP_INSERT;
            OP_DELETE: dec.op = OP_DELETE;
            OP_LEFT:   dec.op = OP_LEFT;
            OP_RIGHT:  dec.op = OP_RIGHT;
            default:   dec.op = OP_INSERT;
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !cmd_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (!push && cmd_pop) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== rtl/gbte_back.sv =====
// ----------------------------------------------------------------------------
// gbte_back: gap buffer execution engine
// Hold the text store and lengths, run the operations, drive the result register.
// ----------------------------------------------------------------------------
module gbte_back
    import gbte_pkg::*;
#(
    parameter int MAX_CHARS = 4096,
    parameter int WINDOW    = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    gbte_out_if.source  out_ch
);

    localparam int AW  = $clog2(MAX_CHARS);
    localparam int LW  = $clog2(MAX_CHARS + 1);
    localparam int WW  = $clog2(WINDOW + 1);
    localparam int CW  = (LW > COUNT_W) ? LW : COUNT_W;
    localparam int WCW = (LW > WW) ? LW : WW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_WIN_SETUP,
        ST_WIN_RD,
        ST_WIN_OUT,
        ST_EMPTY
    } state_t;

    logic [CHAR_W-1:0] mem [MAX_CHARS];

    state_t             state_reg, state_next;
    logic [LW-1:0]      left_reg, left_next;
    logic [LW-1:0]      right_reg, right_next;
    logic [LW-1:0]      cnt_reg, cnt_next;
    logic               dir_reg, dir_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [WW-1:0]      win_reg, win_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_del_reg, out_del_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_cv_reg, out_cv_next;
    logic               out_last_reg, out_last_next;

    logic [CHAR_W-1:0]  rd_data_reg;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [CHAR_W-1:0]  wr_data;

    logic               out_free;
    logic               has_room;
    logic [LW-1:0]      n_left, n_right;
    logic [WW-1:0]      win_w;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.deleted_count = out_del_reg;
    assign out_ch.window_char   = out_char_reg;
    assign out_ch.char_valid    = out_cv_reg;
    assign out_ch.last          = out_last_reg;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign has_room = ((LW+1)'(left_reg) + (LW+1)'(right_reg)) < (LW+1)'(MAX_CHARS);
    assign n_left   = (CW'(cmd.count) < CW'(left_reg))  ? LW'(cmd.count) : left_reg;
    assign n_right  = (CW'(cmd.count) < CW'(right_reg)) ? LW'(cmd.count) : right_reg;
    assign win_w    = (WCW'(left_reg) < WCW'(WINDOW)) ? WW'(left_reg) : WW'(WINDOW);

    always_comb begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        idx_next       = idx_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg;
        out_del_next   = out_del_reg;
        out_char_next  = out_char_reg;
        out_cv_next    = out_cv_reg;
        out_last_next  = out_last_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cmd.ch;

        // Drop the result once the sink takes it
        if (out_valid_reg && out_ch.ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_INSERT: begin
                            if (has_room) begin
                                wr_en     = 1'b1;
                                wr_addr   = AW'(left_reg);
                                left_next = left_reg + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            left_next  = left_reg - n_left;
                            cnt_next   = n_left;
                            state_next = ST_DEL;
                        end
                        OP_LEFT: begin
                            cnt_next   = n_left;
                            dir_next   = 1'b0;
                            state_next = (n_left == '0) ? ST_WIN_SETUP : ST_MOVE_RD;
                        end
                        OP_RIGHT: begin
                            cnt_next   = n_right;
                            dir_next   = 1'b1;
                            state_next = (n_right == '0) ? ST_WIN_SETUP : ST_MOVE_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DEL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_del_next   = COUNT_W'(cnt_reg);
                    out_char_next  = '0;
                    out_cv_next    = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MOVE_RD: begin
                rd_en      = 1'b1;
                rd_addr    = dir_reg ? AW'(LW'(MAX_CHARS) - right_reg)
                                     : AW'(left_reg - 1'b1);
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
                if (dir_reg) begin
                    wr_addr    = AW'(left_reg);
                    left_next  = left_reg + 1'b1;
                    right_next = right_reg - 1'b1;
                end else begin
                    wr_addr    = AW'(LW'(MAX_CHARS - 1) - right_reg);
                    left_next  = left_reg - 1'b1;
                    right_next = right_reg + 1'b1;
                end
                cnt_next   = cnt_reg - 1'b1;
                state_next = (cnt_reg == LW'(1)) ? ST_WIN_SETUP : ST_MOVE_RD;
            end
            ST_WIN_SETUP: begin
                if (win_w == '0) begin
                    state_next = ST_EMPTY;
                end else begin
                    idx_next   = AW'(left_reg - LW'(win_w));
                    win_next   = win_w;
                    state_next = ST_WIN_RD;
                end
            end
            ST_WIN_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_WIN_OUT;
            end
            ST_WIN_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_del_next   = '0;
                    out_char_next  = rd_data_reg;
                    out_cv_next    = 1'b1;
                    out_last_next  = (win_reg == WW'(1));
                    win_next       = win_reg - 1'b1;
                    state_next     = (win_reg == WW'(1)) ? ST_IDLE : ST_WIN_RD;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_del_next   = '0;
                    out_char_next  = '0;
                    out_cv_next    = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            cnt_reg       <= '0;
            dir_reg       <= 1'b0;
            idx_reg       <= '0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_del_reg   <= '0;
            out_char_reg  <= '0;
            out_cv_reg    <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            cnt_reg       <= cnt_next;
            dir_reg       <= dir_next;
            idx_reg       <= idx_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
            out_del_reg   <= out_del_next;
            out_char_reg  <= out_char_next;
            out_cv_reg    <= out_cv_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Text store: one write port, one registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/gap_buffer_text_editor.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_text_editor: gap buffer line editor with cursor window readout
// Flow: an insert gives no result and a delete gives one; a cursor move carries the chars
// across the gap, then streams the window left of the cursor one char per result item
// (one empty result item when the window is empty). The engine takes one item at a time,
// and each char a move carries is read from the text store, then written back to it.
// Reset: lengths go to zero and the queue empties; the text store is not cleared.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor
    import gbte_pkg::*;
#(
    parameter int MAX_CHARS = 4096,
    parameter int WINDOW    = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    gbte_in_if.sink     in_ch,
    gbte_out_if.source  out_ch
);

    // Command queue between the front and the engine; each side stalls on its own
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // Front: accept items, decode mode and hold commands in a short queue
    gbte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back: carry out inserts, deletes and cursor moves on the text store,
    // then stream the window left of the cursor through the result register
    gbte_back #(
        .MAX_CHARS (MAX_CHARS),
        .WINDOW    (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule

// ===== tb/gap_buffer_text_editor_tb.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_text_editor_tb: self-checking bench for the gap buffer editor
// Drives editor operations over the input channel, predicts the window and
// delete reports from a behavioral copy of the gap buffer, and compares every
// result item in order. Covers the empty buffer, saturating counts, zero
// counts, random edit sequences and back-pressure on both channels.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor_tb;
    import gbte_pkg::*;

    localparam int TEXT_CAP   = 4096;
    localparam int VIEW_LEN   = 10;
    localparam int DRAIN_CYC  = 64;
    localparam int HOLD_CYC   = 500;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [COUNT_W-1:0] deleted;
        logic [CHAR_W-1:0]  wchar;
        logic               cvalid;
        logic               last;
    } editor_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    gbte_in_if  in_ch ();
    gbte_out_if out_ch ();

    gap_buffer_text_editor #(
        .MAX_CHARS (TEXT_CAP),
        .WINDOW    (VIEW_LEN)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // Drive the channels from local registers so every input is known at time 0.
    logic tx_valid = 1'b0;
    cmd_t tx_item  = '0;
    logic rx_ready = 1'b0;

    assign in_ch.valid      = tx_valid;
    assign in_ch.mode       = tx_item.op;
    assign in_ch.text_char  = tx_item.ch;
    assign in_ch.move_count = tx_item.count;
    assign out_ch.ready     = rx_ready;

    // Operations waiting to be offered, and results the block still owes.
    cmd_t           pending_ops[$];
    editor_result_t owed_results[$];

    // Behavioral copy of the gap buffer: left text at the bottom, right text
    // at the top, the gap in between.
    logic [CHAR_W-1:0] text_mem [TEXT_CAP];
    int left_len  = 0;
    int right_len = 0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold   = 1'b0;
    logic stress_on = 1'b0;
    int fail_count  = 0;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // Queue up the window of characters left of the cursor, oldest first.
    task automatic owe_window();
        editor_result_t r;
        int w;
        w = (left_len < VIEW_LEN) ? left_len : VIEW_LEN;
        if (w == 0)
        begin
            r = '{deleted: '0, wchar: '0, cvalid: 1'b0, last: 1'b1};
            owed_results = {owed_results, r};
        end
        else
        begin
            for (int i = 0; i < w; i++)
            begin
                r.deleted = '0;
                r.wchar   = text_mem[left_len - w + i];
                r.cvalid  = 1'b1;
                r.last    = (i == w - 1);
                owed_results = {owed_results, r};
            end
        end
    endtask

    // Apply one accepted operation to the buffer copy and owe its results.
    task automatic apply_edit(input cmd_t c);
        editor_result_t r;
        int k;
        int n;
        k = int'(c.count);
        case (c.op)
            OP_INSERT:
            begin
                // Drop the character when the buffer is full.
                if (left_len + right_len < TEXT_CAP)
                begin
                    text_mem[left_len] = c.ch;
                    left_len++;
                end
            end
            OP_DELETE:
            begin
                n = (k < left_len) ? k : left_len;
                left_len -= n;
                r = '{deleted: COUNT_W'(n), wchar: '0, cvalid: 1'b0, last: 1'b1};
                owed_results = {owed_results, r};
            end
            OP_LEFT:
            begin
                n = (k < left_len) ? k : left_len;
                repeat (n)
                begin
                    text_mem[TEXT_CAP - 1 - right_len] = text_mem[left_len - 1];
                    left_len--;
                    right_len++;
                end
                owe_window();
            end
            default:
            begin
                n = (k < right_len) ? k : right_len;
                repeat (n)
                begin
                    text_mem[left_len] = text_mem[TEXT_CAP - right_len];
                    left_len++;
                    right_len--;
                end
                owe_window();
            end
        endcase
    endtask

    // Driver: predict on acceptance, then offer the next pending item or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_valid <= 1'b0;
            tx_item  <= '0;
        end
        else
        begin
            if (tx_valid && in_ch.ready)
                apply_edit(tx_item);
            // Hold the item while it waits for ready.
            if (!tx_valid || in_ch.ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    tx_valid <= 1'b1;
                    tx_item  <= pending_ops[0];
                    pending_ops.delete(0);
                end
                else
                begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // Compare one accepted result against the oldest owed result.
    task automatic check_result();
        editor_result_t want;
        if (owed_results.size() == 0)
        begin
            note_failure($sformatf("unexpected result: del=%0d char=%02h cv=%0b last=%0b",
                out_ch.deleted_count, out_ch.window_char, out_ch.char_valid, out_ch.last));
        end
        else
        begin
            want = owed_results[0];
            owed_results.delete(0);
            if (out_ch.deleted_count !== want.deleted || out_ch.window_char !== want.wchar ||
                out_ch.char_valid !== want.cvalid || out_ch.last !== want.last)
            begin
                note_failure($sformatf(
                    "mismatch del/char/cv/last: exp %0d/%02h/%0b/%0b got %0d/%02h/%0b/%0b",
                    want.deleted, want.wchar, want.cvalid, want.last,
                    out_ch.deleted_count, out_ch.window_char, out_ch.char_valid, out_ch.last));
            end
        end
    endtask

    // Monitor: check on acceptance, then pick the next ready value.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && rx_ready)
                check_result();
            rx_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push_op(input op_t op, input logic [CHAR_W-1:0] ch, input int cnt);
        cmd_t c;
        c.op    = op;
        c.ch    = ch;
        c.count = COUNT_W'(cnt);
        pending_ops = {pending_ops, c};
    endtask

    // Mostly short counts; now and then a large one, up to the full buffer.
    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return TEXT_CAP;
        if (r < 10)
            return $urandom_range(TEXT_CAP, 0);
        return $urandom_range(12, 0);
    endfunction

    task automatic load_directed();
        string word;
        word = "ABCDEFGHIJ";
        // Empty buffer: empty window and a delete that removes nothing.
        push_op(OP_LEFT, 8'h00, 0);
        push_op(OP_DELETE, 8'h00, 5);
        push_op(OP_RIGHT, 8'h00, 3);
        // Extremes of the character field, then a short string.
        push_op(OP_INSERT, 8'h00, 0);
        push_op(OP_INSERT, 8'hFF, TEXT_CAP);
        for (int i = 0; i < word.len(); i++)
            push_op(OP_INSERT, word[i], 0);
        // Zero move, short moves, then moves past the text on each side.
        push_op(OP_LEFT, 8'h00, 0);
        push_op(OP_LEFT, 8'h00, 3);
        push_op(OP_RIGHT, 8'h00, 1);
        push_op(OP_RIGHT, 8'h00, TEXT_CAP);
        push_op(OP_LEFT, 8'h00, TEXT_CAP);
        push_op(OP_RIGHT, 8'h00, 5);
        push_op(OP_DELETE, 8'h00, 2);
        push_op(OP_DELETE, 8'h00, TEXT_CAP);
        push_op(OP_RIGHT, 8'h00, TEXT_CAP);
        push_op(OP_DELETE, 8'h00, 0);
        // Type a longer run so moves carry many characters across the gap.
        for (int i = 0; i < 30; i++)
            push_op(OP_INSERT, 8'($urandom_range(255, 0)), 0);
        push_op(OP_LEFT, 8'h00, 0);
        push_op(OP_LEFT, 8'h00, TEXT_CAP);
        push_op(OP_INSERT, 8'h5A, 0);
        push_op(OP_RIGHT, 8'h00, 2);
        push_op(OP_DELETE, 8'h00, TEXT_CAP);
        push_op(OP_RIGHT, 8'h00, TEXT_CAP);
        push_op(OP_DELETE, 8'h00, TEXT_CAP);
        push_op(OP_LEFT, 8'h00, 1);
    endtask

    // Random edit session: strings typed one character per item, with deletes
    // and cursor moves in between; close with a zero move to read the window.
    task automatic load_random(input int count);
        int i;
        int r;
        int run;
        i = 0;
        while (i < count)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                run = $urandom_range(8, 1);
                repeat (run)
                    push_op(OP_INSERT, 8'($urandom_range(255, 0)), pick_count());
                i += run;
            end
            else
            begin
                if (r < 60)
                    push_op(OP_DELETE, 8'($urandom_range(255, 0)), pick_count());
                else if (r < 80)
                    push_op(OP_LEFT, 8'($urandom_range(255, 0)), pick_count());
                else
                    push_op(OP_RIGHT, 8'($urandom_range(255, 0)), pick_count());
                i++;
            end
        end
        push_op(OP_LEFT, 8'h00, 0);
    endtask

    // Hold the sender off until everything offered has come back.
    task automatic wait_drained();
        while (pending_ops.size() != 0 || tx_valid || owed_results.size() != 0)
            @(negedge clk);
    endtask

    // Long receiver stall in the last phase: the sender keeps offering until
    // the block backs up and drops ready on its input.
    initial
    begin
        wait (stress_on);
        repeat (30) @(negedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 17;
        rx_idle_pct = 69;
        load_directed();
        wait_drained();
        load_random(65);
        wait_drained();

        // Swap the idling between the two sides.
        tx_idle_pct = 69;
        rx_idle_pct = 17;
        load_random(65);
        wait_drained();

        // No idling, plus the long receiver stall.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stress_on   = 1'b1;
        load_random(65);
        wait_drained();

        // Give a trailing insert time to finish and catch stray results.
        repeat (DRAIN_CYC) @(negedge clk);
        if (owed_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", owed_results.size()));

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
